// ----- rtl/hioc_pkg.sv -----
// Package for the hash index engine: field widths, status codes, sizes.
// No dependencies.
`default_nettype none
package hioc_pkg;
  localparam int unsigned KeyW       = 31;
  localparam int unsigned RecW       = 11;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned HomeSlots  = 1024;
  localparam int unsigned SpillSlots = 1024;

  localparam logic [StatusW-1:0] StFound = 2'd0;
  localparam logic [StatusW-1:0] StMiss  = 2'd1;
  localparam logic [StatusW-1:0] StNew   = 2'd2;
  localparam logic [StatusW-1:0] StFull  = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/hioc_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on hioc_pkg.
`default_nettype none
interface hioc_req_if import hioc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            func;
  logic [KeyW-1:0] key;
  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

interface hioc_rsp_if import hioc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [RecW-1:0]    record_index;
  modport source (output valid, status, record_index, input ready);
  modport sink   (input valid, status, record_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/hash_index_overflow_chain.sv -----
// Hash index engine: home table plus overflow chain in synchronous RAMs.
// Each request walks: home read (SHome), home check (SHomeChk), then, on a key
// mismatch, a spill read and check (SSpill, SSpillChk) per chain node; a miss or an
// insert goes through SDecide. One item at a time: a new request is accepted only
// after the result transfer. Reset clears the counters, then a clear pass marks
// every home entry empty before the first input. Depends on hioc_pkg, hioc_if.
`default_nettype none
module hash_index_overflow_chain import hioc_pkg::*; #(
  parameter int unsigned HOME_SLOTS  = HomeSlots,
  parameter int unsigned SPILL_SLOTS = SpillSlots
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hioc_req_if.sink   req,
  hioc_rsp_if.source rsp
);
  localparam int unsigned HW = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1;
  localparam int unsigned LW = $clog2(SPILL_SLOTS + 1);
  localparam int unsigned CW = $clog2(HOME_SLOTS + SPILL_SLOTS + 1);
  localparam logic [LW-1:0] LinkEnd = LW'(SPILL_SLOTS);
  localparam logic [CW-1:0] RecLimit = CW'(HOME_SLOTS + SPILL_SLOTS);
  localparam logic [LW-1:0] SpillLimit = LW'(SPILL_SLOTS);
  localparam int unsigned SW = (SPILL_SLOTS > 1) ? $clog2(SPILL_SLOTS) : 1;
  localparam logic [HW-1:0] ClrLast = HW'(HOME_SLOTS - 1);

  localparam logic [2:0] SIdle = 3'd0, SHome = 3'd1, SHomeChk = 3'd2,
                         SSpill = 3'd3, SSpillChk = 3'd4, SDecide = 3'd5,
                         SOut = 3'd6, SClear = 3'd7;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [LW-1:0]   link;
    logic [RecW-1:0] rec;
  } entry_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [LW-1:0]   link;
    logic [RecW-1:0] rec;
  } home_t;

  // Storage
  home_t  home_mem [HOME_SLOTS];
  entry_t spill_mem [SPILL_SLOTS];
  home_t  home_rd_q;
  entry_t spill_rd_q;

  logic [2:0]       state_q, state_d;
  logic             func_q;
  logic [KeyW-1:0]  key_q;
  logic [HW-1:0]    slot_q;
  logic [HW-1:0]    clr_q;
  logic [LW-1:0]    link_q, link_d;
  logic [LW-1:0]    steps_q, steps_d;
  logic [LW-1:0]    spill_used_q;
  logic [CW-1:0]    rec_used_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [RecW-1:0]  rec_q, rec_d;

  logic             home_we, spill_we, rec_inc;
  home_t            home_wd;
  entry_t           spill_wd;
  logic [HW-1:0]    home_wa;
  logic [SW-1:0]    spill_ra;
  logic [HW-1:0]    slot_in;

  assign slot_in   = HW'(req.key % HOME_SLOTS);
  assign spill_ra  = SW'(link_q);
  assign req.ready = (state_q == SIdle);
  assign rsp.valid = (state_q == SOut);
  assign rsp.status = status_q;
  assign rsp.record_index = rec_q;

  // Home RAM, registered read
  always_ff @(posedge clk_i) begin
    if (home_we) home_mem[home_wa] <= home_wd;
    home_rd_q <= home_mem[slot_q];
  end

  // Spill RAM, registered read
  always_ff @(posedge clk_i) begin
    if (spill_we) spill_mem[SW'(spill_used_q)] <= spill_wd;
    spill_rd_q <= spill_mem[spill_ra];
  end

  // Walk and decide
  always_comb begin
    state_d  = state_q;
    link_d   = link_q;
    steps_d  = steps_q;
    status_d = status_q;
    rec_d    = rec_q;
    home_we  = 1'b0;
    spill_we = 1'b0;
    rec_inc  = 1'b0;
    home_wa  = slot_q;
    home_wd  = '{valid: 1'b1, key: key_q, link: LinkEnd, rec: RecW'(rec_used_q)};
    spill_wd = '{key: key_q, link: home_rd_q.link, rec: RecW'(rec_used_q)};
    unique case (state_q)
      SClear: begin
        home_we = 1'b1;
        home_wa = clr_q;
        home_wd = '{valid: 1'b0, key: '0, link: LinkEnd, rec: '0};
        if (clr_q == ClrLast) state_d = SIdle;
      end
      SIdle: if (req.valid) state_d = SHome;
      SHome: state_d = SHomeChk;
      SHomeChk: begin
        if (!home_rd_q.valid) state_d = SDecide;
        else if (home_rd_q.key == key_q) begin
          status_d = StFound; rec_d = home_rd_q.rec; state_d = SOut;
        end else begin
          link_d = home_rd_q.link; steps_d = '0;
          state_d = (home_rd_q.link >= LinkEnd) ? SDecide : SSpill;
        end
      end
      SSpill: state_d = SSpillChk;
      SSpillChk: begin
        if (spill_rd_q.key == key_q) begin
          status_d = StFound; rec_d = spill_rd_q.rec; state_d = SOut;
        end else begin
          link_d = spill_rd_q.link; steps_d = steps_q + 1'b1;
          state_d = (spill_rd_q.link >= LinkEnd || steps_q + 1'b1 >= SpillLimit)
                    ? SDecide : SSpill;
        end
      end
      SDecide: begin
        state_d = SOut;
        rec_d   = '0;
        if (!func_q) status_d = StMiss;
        else if (rec_used_q >= RecLimit) status_d = StFull;
        else if (!home_rd_q.valid) begin
          home_we = 1'b1; rec_inc = 1'b1;
          status_d = StNew; rec_d = RecW'(rec_used_q);
        end else if (spill_used_q >= SpillLimit) status_d = StFull;
        else begin
          spill_we = 1'b1; home_we = 1'b1; rec_inc = 1'b1;
          home_wd = '{valid: 1'b1, key: home_rd_q.key, link: spill_used_q,
                      rec: home_rd_q.rec};
          status_d = StNew; rec_d = RecW'(rec_used_q);
        end
      end
      SOut: if (rsp.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClear;
      clr_q        <= '0;
      spill_used_q <= '0;
      rec_used_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SClear) clr_q <= clr_q + 1'b1;
      if (rec_inc) rec_used_q <= rec_used_q + 1'b1;
      if (spill_we) spill_used_q <= spill_used_q + 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && req.valid) begin
      func_q <= req.func;
      key_q  <= req.key;
      slot_q <= slot_in;
    end
    link_q   <= link_d;
    steps_q  <= steps_d;
    status_q <= status_d;
    rec_q    <= rec_d;
  end

  // Checks
  a_spill_le_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(spill_used_q) <= rec_used_q) else $error("spill count exceeds records");
  a_one_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spill_we |-> home_we) else $error("spill write without home link update");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.ready && rsp.valid)) else $error("accept while result pending");
  a_new_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_inc |=> rec_used_q == $past(rec_used_q) + 1'b1) else $error("record count");
endmodule
`default_nettype wire
